// ===== rtl/brcag_pkg.sv =====
// shared types, constants and helpers for the blit rectangle clip address generator
package brcag_pkg;

   localparam int DIM_W     = 13;  // sizes and pitches
   localparam int COORD_W   = 14;  // signed command coordinates
   localparam int WIDE_W    = 16;  // signed internal coordinates
   localparam int PIX_W     = 12;  // clipped coordinates, 0..MAX_DIM-1
   localparam int FMT_W     = 2;
   localparam int KIND_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W    = DIM_W + PIX_W;
   localparam int OFS_W     = 26;
   localparam int PIXOFS_W  = OFS_W - 2;  // four bytes per pixel
   localparam int ROWB_W    = 15;

   localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

   localparam logic [KIND_W-1:0] KIND_COPY_ALL  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COPY_AREA = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MOVE      = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE      = 2'd3;

   localparam logic [FMT_W-1:0] FMT_RGB32 = 2'd0;
   localparam logic [FMT_W-1:0] FMT_BGR32 = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_PITCH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_FORMAT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_PITCH  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_FORMAT = 3'd7;

   typedef struct packed {
      logic [DIM_W-1:0] dst_width;
      logic [DIM_W-1:0] dst_height;
      logic [DIM_W-1:0] dst_line_pitch;
      logic [FMT_W-1:0] dst_pixel_format;
      logic [DIM_W-1:0] src_width;
      logic [DIM_W-1:0] src_height;
      logic [DIM_W-1:0] src_line_pitch;
      logic [FMT_W-1:0] src_pixel_format;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] rect_x;
      logic signed [COORD_W-1:0] rect_y;
      logic [DIM_W-1:0]          rect_w;
      logic [DIM_W-1:0]          rect_h;
   } cmd_type;

   // clip bounds, before widths and row selection
   typedef struct packed {
      logic                     zero;    // nothing to copy (error or unknown kind)
      logic                     status;
      logic                     desc;
      logic signed [WIDE_W-1:0] ox;
      logic signed [WIDE_W-1:0] oy;
      logic signed [WIDE_W-1:0] x0;
      logic signed [WIDE_W-1:0] y0;
      logic signed [WIDE_W-1:0] x1;
      logic signed [WIDE_W-1:0] y1;
      logic [DIM_W-1:0]         spitch;
   } bounds_type;

   typedef struct packed {
      logic             ok;      // non-empty, valid copy
      logic             status;
      logic             desc;
      logic [PIX_W-1:0] x0;
      logic [PIX_W-1:0] sx;
      logic [PIX_W-1:0] dy;
      logic [PIX_W-1:0] sy;
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      logic [DIM_W-1:0] spitch;
   } clip_type;

   typedef struct packed {
      logic              ok;
      logic              status;
      logic              desc;
      logic [PIX_W-1:0]  x0;
      logic [PIX_W-1:0]  sx;
      logic [DIM_W-1:0]  w;
      logic [DIM_W-1:0]  h;
      logic [PROD_W-1:0] dprod;
      logic [PROD_W-1:0] sprod;
   } mul_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      return (v > MAX_DIM) ? MAX_DIM : v;
   endfunction

   function automatic logic signed [WIDE_W-1:0] smax(input logic signed [WIDE_W-1:0] a,
                                                     input logic signed [WIDE_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic signed [WIDE_W-1:0] smin(input logic signed [WIDE_W-1:0] a,
                                                     input logic signed [WIDE_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

// ===== rtl/brcag_clip.sv =====
// two-stage rectangle clipper: bounds, then width, height and start rows
module brcag_clip (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  brcag_pkg::cmd_type cmd,
   input  brcag_pkg::cfg_type cfg,
   output logic               out_valid,
   output brcag_pkg::clip_type out_clip
);

   logic                            bnd_vld_ff;
   brcag_pkg::bounds_type           bnd_in;
   brcag_pkg::bounds_type           bnd_ff;
   logic                            clip_vld_ff;
   brcag_pkg::clip_type             clip_in;
   brcag_pkg::clip_type             clip_ff;

   logic signed [brcag_pkg::WIDE_W-1:0] px, py, rx, ry, rw, rh, sw, sh, dw, dh;
   logic signed [brcag_pkg::WIDE_W-1:0] w_s, h_s, dy_s, sy_s, sx_s;
   logic                                fmt_err, empty;

   // stage 1: select operands and intersect the three rectangles
   always_comb begin
      px = {{2{cmd.pos_x[brcag_pkg::COORD_W-1]}}, cmd.pos_x};
      py = {{2{cmd.pos_y[brcag_pkg::COORD_W-1]}}, cmd.pos_y};
      rx = {{2{cmd.rect_x[brcag_pkg::COORD_W-1]}}, cmd.rect_x};
      ry = {{2{cmd.rect_y[brcag_pkg::COORD_W-1]}}, cmd.rect_y};
      rw = {3'b000, brcag_pkg::clamp_dim(cmd.rect_w)};
      rh = {3'b000, brcag_pkg::clamp_dim(cmd.rect_h)};
      dw = {3'b000, brcag_pkg::clamp_dim(cfg.dst_width)};
      dh = {3'b000, brcag_pkg::clamp_dim(cfg.dst_height)};
      sw = {3'b000, brcag_pkg::clamp_dim(cfg.src_width)};
      sh = {3'b000, brcag_pkg::clamp_dim(cfg.src_height)};
      bnd_in.spitch = cfg.src_line_pitch;
      bnd_in.desc   = 1'b0;
      fmt_err = (cfg.dst_pixel_format != cfg.src_pixel_format) ||
                (cfg.dst_pixel_format[1] != 1'b0);

      case (cmd.kind)
         brcag_pkg::KIND_MOVE: begin
            // the source is the destination buffer itself
            sw            = dw;
            sh            = dh;
            bnd_in.spitch = cfg.dst_line_pitch;
            bnd_in.desc   = (py >= ry);
            fmt_err       = (cfg.dst_pixel_format[1] != 1'b0);
         end
         brcag_pkg::KIND_COPY_ALL: begin
            rx = '0;
            ry = '0;
            rw = sw;
            rh = sh;
         end
         default: begin
         end
      endcase

      bnd_in.status = fmt_err && (cmd.kind != brcag_pkg::KIND_NONE);
      bnd_in.zero   = fmt_err || (cmd.kind == brcag_pkg::KIND_NONE);
      bnd_in.ox     = px - rx;
      bnd_in.oy     = py - ry;
      bnd_in.x0     = brcag_pkg::smax(brcag_pkg::smax('0, px), bnd_in.ox);
      bnd_in.y0     = brcag_pkg::smax(brcag_pkg::smax('0, py), bnd_in.oy);
      bnd_in.x1     = brcag_pkg::smin(brcag_pkg::smin(dw, px + rw), bnd_in.ox + sw);
      bnd_in.y1     = brcag_pkg::smin(brcag_pkg::smin(dh, py + rh), bnd_in.oy + sh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_vld_ff <= 1'b0;
      end else begin
         bnd_vld_ff <= in_valid;
      end
      bnd_ff <= bnd_in;
   end

   // stage 2: size of the clip and first row in each buffer
   always_comb begin
      empty = (bnd_ff.x1 <= bnd_ff.x0) || (bnd_ff.y1 <= bnd_ff.y0);
      w_s   = bnd_ff.x1 - bnd_ff.x0;
      h_s   = bnd_ff.y1 - bnd_ff.y0;
      // descending copies start on the last row
      dy_s  = bnd_ff.desc ? (bnd_ff.y1 - 16'sd1) : bnd_ff.y0;
      sy_s  = dy_s - bnd_ff.oy;
      sx_s  = bnd_ff.x0 - bnd_ff.ox;

      clip_in.ok     = !bnd_ff.zero && !empty;
      clip_in.status = bnd_ff.status;
      clip_in.desc   = bnd_ff.desc;
      clip_in.x0     = bnd_ff.x0[brcag_pkg::PIX_W-1:0];
      clip_in.sx     = sx_s[brcag_pkg::PIX_W-1:0];
      clip_in.dy     = dy_s[brcag_pkg::PIX_W-1:0];
      clip_in.sy     = sy_s[brcag_pkg::PIX_W-1:0];
      clip_in.w      = w_s[brcag_pkg::DIM_W-1:0];
      clip_in.h      = h_s[brcag_pkg::DIM_W-1:0];
      clip_in.spitch = bnd_ff.spitch;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_vld_ff <= 1'b0;
      end else begin
         clip_vld_ff <= bnd_vld_ff;
      end
      clip_ff <= clip_in;
   end

   assign out_valid = clip_vld_ff;
   assign out_clip  = clip_ff;

endmodule

// ===== rtl/blit_rect_clip_address_gen_unit.sv =====
// top level of the 2d blit rectangle clip and address generator
// Usage:
//   Write the eight frame buffer registers through csr_we / csr_index / csr_wdata
//   while no command is in flight; a write takes effect at the clock edge.
//   A command word is taken at each rising edge with start high and busy low.
//   busy stays low: a new command may be issued in every cycle.
//   Each command gives exactly one descriptor word: rsp_strobe is high for one
//   cycle with the descriptor fields, and the word is taken at the edge that
//   ends that cycle. The receiver cannot stall the block.
//   rsp_strobe goes high once the command has passed the input register, the clip
//   bounds, clip size and row multiply registers, then the offset add in front
//   of the output register.
//   Throughput is one command per cycle; the two pitch-times-row multipliers
//   sit in a stage of their own.
//   Format errors give status 1 with all other fields zero; an empty clip or
//   an unknown kind gives status 0 with all fields zero.
//   Synchronous reset clears the frame buffer registers to zero and drops all
//   commands in flight; no descriptor is produced for them.
module blit_rect_clip_address_gen_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [brcag_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [brcag_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [brcag_pkg::COORD_W-1:0] req_pos_y,
   input  logic signed [brcag_pkg::COORD_W-1:0] req_rect_x,
   input  logic signed [brcag_pkg::COORD_W-1:0] req_rect_y,
   input  logic [brcag_pkg::DIM_W-1:0]         req_rect_w,
   input  logic [brcag_pkg::DIM_W-1:0]         req_rect_h,
   input  logic                                csr_we,
   input  logic [brcag_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [brcag_pkg::DIM_W-1:0]         csr_wdata,
   output logic                                rsp_strobe,
   output logic                                rsp_status,
   output logic [brcag_pkg::OFS_W-1:0]         rsp_dst_offset,
   output logic [brcag_pkg::OFS_W-1:0]         rsp_src_offset,
   output logic [brcag_pkg::ROWB_W-1:0]        rsp_row_bytes,
   output logic [brcag_pkg::DIM_W-1:0]         rsp_row_count,
   output logic                                rsp_descending
);

   brcag_pkg::cfg_type  cfg_in, cfg_ff;
   brcag_pkg::cmd_type  cmd_in, cmd_ff;
   logic                cmd_vld_ff;
   logic                clip_vld;
   brcag_pkg::clip_type clip;
   brcag_pkg::mul_type  mul_in, mul_ff;
   logic                mul_vld_ff;

   logic [brcag_pkg::PROD_W-1:0] dsum, ssum;

   logic                          strobe_ff;
   logic                          status_ff;
   logic [brcag_pkg::OFS_W-1:0]   dofs_ff, dofs_in;
   logic [brcag_pkg::OFS_W-1:0]   sofs_ff, sofs_in;
   logic [brcag_pkg::ROWB_W-1:0]  rowb_ff, rowb_in;
   logic [brcag_pkg::DIM_W-1:0]   rows_ff, rows_in;
   logic                          desc_ff, desc_in;

   assign busy = 1'b0;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            brcag_pkg::CSR_DST_WIDTH:  cfg_in.dst_width        = csr_wdata;
            brcag_pkg::CSR_DST_HEIGHT: cfg_in.dst_height       = csr_wdata;
            brcag_pkg::CSR_DST_PITCH:  cfg_in.dst_line_pitch   = csr_wdata;
            brcag_pkg::CSR_DST_FORMAT: cfg_in.dst_pixel_format =
                                          csr_wdata[brcag_pkg::FMT_W-1:0];
            brcag_pkg::CSR_SRC_WIDTH:  cfg_in.src_width        = csr_wdata;
            brcag_pkg::CSR_SRC_HEIGHT: cfg_in.src_height       = csr_wdata;
            brcag_pkg::CSR_SRC_PITCH:  cfg_in.src_line_pitch   = csr_wdata;
            brcag_pkg::CSR_SRC_FORMAT: cfg_in.src_pixel_format =
                                          csr_wdata[brcag_pkg::FMT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // command input register
   always_comb begin
      cmd_in.kind   = req_kind;
      cmd_in.pos_x  = req_pos_x;
      cmd_in.pos_y  = req_pos_y;
      cmd_in.rect_x = req_rect_x;
      cmd_in.rect_y = req_rect_y;
      cmd_in.rect_w = req_rect_w;
      cmd_in.rect_h = req_rect_h;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_vld_ff <= 1'b0;
      end else begin
         cmd_vld_ff <= start && !busy;
      end
      if (start && !busy) begin
         cmd_ff <= cmd_in;
      end
   end

   brcag_clip u_clip (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmd_vld_ff),
      .cmd       (cmd_ff),
      .cfg       (cfg_ff),
      .out_valid (clip_vld),
      .out_clip  (clip)
   );

   // row times pitch for both buffers
   always_comb begin
      mul_in.ok     = clip.ok;
      mul_in.status = clip.status;
      mul_in.desc   = clip.desc;
      mul_in.x0     = clip.x0;
      mul_in.sx     = clip.sx;
      mul_in.w      = clip.w;
      mul_in.h      = clip.h;
      mul_in.dprod  = {{(brcag_pkg::PROD_W-brcag_pkg::DIM_W){1'b0}}, cfg_ff.dst_line_pitch} *
                      {{(brcag_pkg::PROD_W-brcag_pkg::PIX_W){1'b0}}, clip.dy};
      mul_in.sprod  = {{(brcag_pkg::PROD_W-brcag_pkg::DIM_W){1'b0}}, clip.spitch} *
                      {{(brcag_pkg::PROD_W-brcag_pkg::PIX_W){1'b0}}, clip.sy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= clip_vld;
      end
      mul_ff <= mul_in;
   end

   // add the column, scale to bytes, zero all fields but the status when nothing is copied
   always_comb begin
      dsum    = mul_ff.dprod + {{(brcag_pkg::PROD_W-brcag_pkg::PIX_W){1'b0}}, mul_ff.x0};
      ssum    = mul_ff.sprod + {{(brcag_pkg::PROD_W-brcag_pkg::PIX_W){1'b0}}, mul_ff.sx};
      dofs_in = '0;
      sofs_in = '0;
      rowb_in = '0;
      rows_in = '0;
      desc_in = 1'b0;
      if (mul_ff.ok) begin
         dofs_in = {dsum[brcag_pkg::PIXOFS_W-1:0], 2'b00};
         sofs_in = {ssum[brcag_pkg::PIXOFS_W-1:0], 2'b00};
         rowb_in = {mul_ff.w, 2'b00};
         rows_in = mul_ff.h;
         desc_in = mul_ff.desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= mul_vld_ff;
      end
      status_ff <= mul_ff.status;
      dofs_ff   <= dofs_in;
      sofs_ff   <= sofs_in;
      rowb_ff   <= rowb_in;
      rows_ff   <= rows_in;
      desc_ff   <= desc_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_status     = status_ff;
   assign rsp_dst_offset = dofs_ff;
   assign rsp_src_offset = sofs_ff;
   assign rsp_row_bytes  = rowb_ff;
   assign rsp_row_count  = rows_ff;
   assign rsp_descending = desc_ff;

endmodule

// ===== dv/blit_rect_clip_address_gen_unit_test.sv =====
// self-checking testbench for the blit rectangle clip and address generator
module blit_rect_clip_address_gen_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic                         status;
      logic [brcag_pkg::OFS_W-1:0]  dst_offset;
      logic [brcag_pkg::OFS_W-1:0]  src_offset;
      logic [brcag_pkg::ROWB_W-1:0] row_bytes;
      logic [brcag_pkg::DIM_W-1:0]  row_count;
      logic                         descending;
   } descriptor_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic [brcag_pkg::KIND_W-1:0]         req_kind;
   logic signed [brcag_pkg::COORD_W-1:0] req_pos_x;
   logic signed [brcag_pkg::COORD_W-1:0] req_pos_y;
   logic signed [brcag_pkg::COORD_W-1:0] req_rect_x;
   logic signed [brcag_pkg::COORD_W-1:0] req_rect_y;
   logic [brcag_pkg::DIM_W-1:0]          req_rect_w;
   logic [brcag_pkg::DIM_W-1:0]          req_rect_h;
   logic                                 csr_we;
   logic [brcag_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [brcag_pkg::DIM_W-1:0]          csr_wdata;
   logic                                 rsp_strobe;
   logic                                 rsp_status;
   logic [brcag_pkg::OFS_W-1:0]          rsp_dst_offset;
   logic [brcag_pkg::OFS_W-1:0]          rsp_src_offset;
   logic [brcag_pkg::ROWB_W-1:0]         rsp_row_bytes;
   logic [brcag_pkg::DIM_W-1:0]          rsp_row_count;
   logic                                 rsp_descending;

   brcag_pkg::cfg_type fb_cfg;
   descriptor_type     pending_descriptors[$];
   int                 mismatch_count;
   bit                 idle_enable;

   blit_rect_clip_address_gen_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_rect_x     (req_rect_x),
      .req_rect_y     (req_rect_y),
      .req_rect_w     (req_rect_w),
      .req_rect_h     (req_rect_h),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_dst_offset (rsp_dst_offset),
      .rsp_src_offset (rsp_src_offset),
      .rsp_row_bytes  (rsp_row_bytes),
      .rsp_row_count  (rsp_row_count),
      .rsp_descending (rsp_descending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #500000;
      $display("blit_rect_clip_address_gen_unit regression: fail");
      $finish;
   end

   // ---------------- descriptor prediction ----------------

   function automatic int fit_dim(input logic [brcag_pkg::DIM_W-1:0] v);
      return (v > brcag_pkg::MAX_DIM) ? int'(brcag_pkg::MAX_DIM) : int'(v);
   endfunction

   function automatic int larger(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   function automatic int smaller(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [brcag_pkg::OFS_W-1:0] byte_ofs(
         input int x, input int y, input logic [brcag_pkg::DIM_W-1:0] pitch);
      logic [63:0] pix;
      pix = 64'(x) + 64'(pitch) * 64'(y);
      return {pix[brcag_pkg::OFS_W-3:0], 2'b00};
   endfunction

   function automatic descriptor_type predict_descriptor(input brcag_pkg::cmd_type c,
                                                         input brcag_pkg::cfg_type g);
      descriptor_type              d;
      int                          px, py, rx, ry, rw, rh, dw, dh, sw, sh;
      int                          ox, oy, x0, y0, x1, y1, w, h, dy, sy;
      logic [31:0]                 rowb, rows;
      logic [brcag_pkg::DIM_W-1:0] spitch;
      logic                        desc;
      d = '0;
      px = $signed(c.pos_x);
      py = $signed(c.pos_y);
      rx = $signed(c.rect_x);
      ry = $signed(c.rect_y);
      rw = fit_dim(c.rect_w);
      rh = fit_dim(c.rect_h);
      dw = fit_dim(g.dst_width);
      dh = fit_dim(g.dst_height);
      desc = 1'b0;
      if (c.kind == brcag_pkg::KIND_NONE) return d;
      if (c.kind == brcag_pkg::KIND_MOVE) begin
         if (g.dst_pixel_format > brcag_pkg::FMT_BGR32) begin
            d.status = 1'b1;
            return d;
         end
         // source is the destination buffer itself
         sw = dw;
         sh = dh;
         spitch = g.dst_line_pitch;
         desc = (py >= ry);
      end else begin
         if (g.dst_pixel_format != g.src_pixel_format ||
             g.dst_pixel_format > brcag_pkg::FMT_BGR32) begin
            d.status = 1'b1;
            return d;
         end
         sw = fit_dim(g.src_width);
         sh = fit_dim(g.src_height);
         spitch = g.src_line_pitch;
         if (c.kind == brcag_pkg::KIND_COPY_ALL) begin
            rx = 0;
            ry = 0;
            rw = sw;
            rh = sh;
         end
      end
      // source buffer origin in destination coordinates
      ox = px - rx;
      oy = py - ry;
      x0 = larger(larger(0, px), ox);
      y0 = larger(larger(0, py), oy);
      x1 = smaller(smaller(dw, px + rw), ox + sw);
      y1 = smaller(smaller(dh, py + rh), oy + sh);
      if (x1 <= x0 || y1 <= y0) return d;
      w = x1 - x0;
      h = y1 - y0;
      dy = desc ? y0 + h - 1 : y0;
      sy = dy - oy;
      rowb = 32'(w * 4);
      rows = 32'(h);
      d.dst_offset = byte_ofs(x0, dy, g.dst_line_pitch);
      d.src_offset = byte_ofs(x0 - ox, sy, spitch);
      d.row_bytes  = rowb[brcag_pkg::ROWB_W-1:0];
      d.row_count  = rows[brcag_pkg::DIM_W-1:0];
      d.descending = desc;
      return d;
   endfunction

   // ---------------- checking ----------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch on %0s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      descriptor_type want;
      if (!reset && rsp_strobe) begin
         if (pending_descriptors.size() == 0) begin
            report_mismatch("unexpected word", 64'(rsp_status), 64'(0));
         end else begin
            want = pending_descriptors.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (rsp_dst_offset !== want.dst_offset)
               report_mismatch("dst_offset", 64'(rsp_dst_offset), 64'(want.dst_offset));
            if (rsp_src_offset !== want.src_offset)
               report_mismatch("src_offset", 64'(rsp_src_offset), 64'(want.src_offset));
            if (rsp_row_bytes !== want.row_bytes)
               report_mismatch("row_bytes", 64'(rsp_row_bytes), 64'(want.row_bytes));
            if (rsp_row_count !== want.row_count)
               report_mismatch("row_count", 64'(rsp_row_count), 64'(want.row_count));
            if (rsp_descending !== want.descending)
               report_mismatch("descending", 64'(rsp_descending), 64'(want.descending));
         end
      end
   end

   // ---------------- drivers ----------------

   task automatic issue_cmd(input brcag_pkg::cmd_type c);
      if (idle_enable)
         while ($urandom_range(99) < 21) begin
            @(negedge clock);
            start <= 1'b0;
         end
      @(negedge clock);
      start      <= 1'b1;
      req_kind   <= c.kind;
      req_pos_x  <= c.pos_x;
      req_pos_y  <= c.pos_y;
      req_rect_x <= c.rect_x;
      req_rect_y <= c.rect_y;
      req_rect_w <= c.rect_w;
      req_rect_h <= c.rect_h;
      do @(posedge clock); while (busy);
      pending_descriptors.push_back(predict_descriptor(c, fb_cfg));
   endtask

   // stop issuing and let every outstanding word come back
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_descriptors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [brcag_pkg::CSR_IDX_W-1:0] idx,
                            input logic [brcag_pkg::DIM_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         brcag_pkg::CSR_DST_WIDTH:  fb_cfg.dst_width        = val;
         brcag_pkg::CSR_DST_HEIGHT: fb_cfg.dst_height       = val;
         brcag_pkg::CSR_DST_PITCH:  fb_cfg.dst_line_pitch   = val;
         brcag_pkg::CSR_DST_FORMAT: fb_cfg.dst_pixel_format = val[brcag_pkg::FMT_W-1:0];
         brcag_pkg::CSR_SRC_WIDTH:  fb_cfg.src_width        = val;
         brcag_pkg::CSR_SRC_HEIGHT: fb_cfg.src_height       = val;
         brcag_pkg::CSR_SRC_PITCH:  fb_cfg.src_line_pitch   = val;
         brcag_pkg::CSR_SRC_FORMAT: fb_cfg.src_pixel_format = val[brcag_pkg::FMT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_config(input brcag_pkg::cfg_type g);
      settle();
      write_reg(brcag_pkg::CSR_DST_WIDTH, g.dst_width);
      write_reg(brcag_pkg::CSR_DST_HEIGHT, g.dst_height);
      write_reg(brcag_pkg::CSR_DST_PITCH, g.dst_line_pitch);
      write_reg(brcag_pkg::CSR_DST_FORMAT,
                {{(brcag_pkg::DIM_W-brcag_pkg::FMT_W){1'b0}}, g.dst_pixel_format});
      write_reg(brcag_pkg::CSR_SRC_WIDTH, g.src_width);
      write_reg(brcag_pkg::CSR_SRC_HEIGHT, g.src_height);
      write_reg(brcag_pkg::CSR_SRC_PITCH, g.src_line_pitch);
      write_reg(brcag_pkg::CSR_SRC_FORMAT,
                {{(brcag_pkg::DIM_W-brcag_pkg::FMT_W){1'b0}}, g.src_pixel_format});
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic brcag_pkg::cfg_type make_cfg(
         input int dw, input int dh, input int dp,
         input logic [brcag_pkg::FMT_W-1:0] df, input int sw,
         input int sh, input int sp,
         input logic [brcag_pkg::FMT_W-1:0] sf);
      brcag_pkg::cfg_type g;
      g.dst_width        = dw[brcag_pkg::DIM_W-1:0];
      g.dst_height       = dh[brcag_pkg::DIM_W-1:0];
      g.dst_line_pitch   = dp[brcag_pkg::DIM_W-1:0];
      g.dst_pixel_format = df;
      g.src_width        = sw[brcag_pkg::DIM_W-1:0];
      g.src_height       = sh[brcag_pkg::DIM_W-1:0];
      g.src_line_pitch   = sp[brcag_pkg::DIM_W-1:0];
      g.src_pixel_format = sf;
      return g;
   endfunction

   function automatic brcag_pkg::cmd_type make_cmd(
         input logic [brcag_pkg::KIND_W-1:0] kind, input int px,
         input int py, input int rx, input int ry,
         input int rw, input int rh);
      brcag_pkg::cmd_type c;
      c.kind   = kind;
      c.pos_x  = px[brcag_pkg::COORD_W-1:0];
      c.pos_y  = py[brcag_pkg::COORD_W-1:0];
      c.rect_x = rx[brcag_pkg::COORD_W-1:0];
      c.rect_y = ry[brcag_pkg::COORD_W-1:0];
      c.rect_w = rw[brcag_pkg::DIM_W-1:0];
      c.rect_h = rh[brcag_pkg::DIM_W-1:0];
      return c;
   endfunction

   // ---------------- random generation ----------------

   function automatic logic [brcag_pkg::COORD_W-1:0] rand_coord(input int span);
      logic [31:0] v;
      if ($urandom_range(9) == 0) v = $urandom_range(16383);
      else v = $urandom_range(2 * span) - span;
      return v[brcag_pkg::COORD_W-1:0];
   endfunction

   function automatic logic [brcag_pkg::DIM_W-1:0] rand_size(input int span);
      logic [31:0] v;
      if ($urandom_range(9) == 0) v = $urandom_range(8191);
      else v = $urandom_range(span);
      return v[brcag_pkg::DIM_W-1:0];
   endfunction

   function automatic logic [brcag_pkg::DIM_W-1:0] rand_dim(input int mode);
      logic [31:0] v;
      case (mode)
         0:       v = $urandom_range(40, 1);
         1:       v = $urandom_range(700);
         2:       v = $urandom_range(8191);
         default: v = ($urandom_range(1) == 0) ? 32'(brcag_pkg::MAX_DIM) : 32'd8191;
      endcase
      return v[brcag_pkg::DIM_W-1:0];
   endfunction

   function automatic logic [brcag_pkg::DIM_W-1:0] rand_pitch(
         input int mode, input logic [brcag_pkg::DIM_W-1:0] w);
      logic [31:0] v;
      if (mode == 2) v = $urandom_range(8191);
      else if (mode == 3) v = ($urandom_range(1) == 0) ? 32'd8191 : 32'd0;
      else v = 32'(w) + $urandom_range(8);
      return v[brcag_pkg::DIM_W-1:0];
   endfunction

   function automatic brcag_pkg::cfg_type random_cfg(input int mode);
      brcag_pkg::cfg_type g;
      logic [31:0]        f;
      g.dst_width      = rand_dim(mode);
      g.dst_height     = rand_dim(mode);
      g.dst_line_pitch = rand_pitch(mode, g.dst_width);
      g.src_width      = rand_dim(mode);
      g.src_height     = rand_dim(mode);
      g.src_line_pitch = rand_pitch(mode, g.src_width);
      // mostly matching known formats so that copies get through
      if ($urandom_range(9) < 8) begin
         f = $urandom_range(1);
         g.dst_pixel_format = f[brcag_pkg::FMT_W-1:0];
         g.src_pixel_format = g.dst_pixel_format;
      end else begin
         f = $urandom_range(3);
         g.dst_pixel_format = f[brcag_pkg::FMT_W-1:0];
         f = $urandom_range(3);
         g.src_pixel_format = f[brcag_pkg::FMT_W-1:0];
      end
      return g;
   endfunction

   function automatic brcag_pkg::cmd_type random_cmd(input brcag_pkg::cfg_type g);
      brcag_pkg::cmd_type c;
      int                 span;
      logic [31:0]        k;
      span = larger(larger(fit_dim(g.dst_width), fit_dim(g.dst_height)),
                    larger(fit_dim(g.src_width), fit_dim(g.src_height))) + 8;
      k = $urandom_range(2);
      c.kind   = ($urandom_range(99) < 4) ? brcag_pkg::KIND_NONE
                                          : k[brcag_pkg::KIND_W-1:0];
      c.pos_x  = rand_coord(span);
      c.pos_y  = rand_coord(span);
      c.rect_x = rand_coord(span);
      c.rect_y = rand_coord(span);
      c.rect_w = rand_size(span);
      c.rect_h = rand_size(span);
      return c;
   endfunction

   // ---------------- tests ----------------

   // registers are all zero: empty buffers, equal formats
   task automatic test_reset_defaults();
      issue_cmd(make_cmd(brcag_pkg::KIND_COPY_ALL, 0, 0, 0, 0, 10, 10));
      issue_cmd(make_cmd(brcag_pkg::KIND_COPY_AREA, 3, 4, 0, 0, 10, 10));
      issue_cmd(make_cmd(brcag_pkg::KIND_MOVE, 5, 5, 0, 0, 10, 10));
   endtask

   task automatic test_copy_whole();
      load_config(make_cfg(640, 480, 648, brcag_pkg::FMT_RGB32,
                           100, 60, 104, brcag_pkg::FMT_RGB32));
      issue_cmd(make_cmd(brcag_pkg::KIND_COPY_ALL, 10, 20, 1, 2, 3, 4));
      // left and top clipped
      issue_cmd(make_cmd(brcag_pkg::KIND_COPY_ALL, -30, -5, 0, 0, 0, 0));
      // right and bottom clipped
      issue_cmd(make_cmd(brcag_pkg::KIND_COPY_ALL, 600, 450, 0, 0, 0, 0));
      // touches left edge only
      issue_cmd(make_cmd(brcag_pkg::KIND_COPY_ALL, -100, 0, 0, 0, 0, 0));
      issue_cmd(make_cmd(brcag_pkg::KIND_COPY_ALL, -8192, 8191, 0, 0, 0, 0));
   endtask

   task automatic test_copy_area();
      load_config(make_cfg(320, 200, 320, brcag_pkg::FMT_BGR32,
                           100, 60, 128, brcag_pkg::FMT_BGR32));
      issue_cmd(make_cmd(brcag_pkg::KIND_COPY_AREA, 5, 5, 10, 10, 20, 30));
      // area starts off the source
      issue_cmd(make_cmd(brcag_pkg::KIND_COPY_AREA, 5, 5, -5, -5, 40, 40));
      // zero width
      issue_cmd(make_cmd(brcag_pkg::KIND_COPY_AREA, 5, 5, 10, 10, 0, 30));
      issue_cmd(make_cmd(brcag_pkg::KIND_COPY_AREA, 300, 190, 90, 50, 50, 50));
   endtask

   task automatic test_move();
      load_config(make_cfg(256, 256, 260, brcag_pkg::FMT_RGB32,
                           0, 0, 0, brcag_pkg::FMT_BGR32));
      issue_cmd(make_cmd(brcag_pkg::KIND_MOVE, 100, 100, 50, 50, 64, 32)); // moving down
      issue_cmd(make_cmd(brcag_pkg::KIND_MOVE, 100, 10, 100, 50, 64, 32)); // moving up
      issue_cmd(make_cmd(brcag_pkg::KIND_MOVE, 120, 40, 100, 40, 64, 32)); // same row
      issue_cmd(make_cmd(brcag_pkg::KIND_MOVE, -10, 200, 0, 0, 64, 64));
   endtask

   task automatic test_format_checks();
      load_config(make_cfg(64, 64, 64, brcag_pkg::FMT_RGB32,
                           32, 32, 32, brcag_pkg::FMT_BGR32));
      issue_cmd(make_cmd(brcag_pkg::KIND_COPY_ALL, 0, 0, 0, 0, 0, 0));
      issue_cmd(make_cmd(brcag_pkg::KIND_MOVE, 8, 8, 0, 0, 16, 16));
      load_config(make_cfg(64, 64, 64, 2'd2, 32, 32, 32, 2'd2));
      issue_cmd(make_cmd(brcag_pkg::KIND_COPY_AREA, 0, 0, 0, 0, 8, 8));
      load_config(make_cfg(64, 64, 64, 2'd3, 32, 32, 32, brcag_pkg::FMT_RGB32));
      issue_cmd(make_cmd(brcag_pkg::KIND_MOVE, 8, 8, 0, 0, 16, 16));
   endtask

   task automatic test_unknown_kind();
      load_config(make_cfg(64, 64, 64, brcag_pkg::FMT_RGB32,
                           32, 32, 32, brcag_pkg::FMT_RGB32));
      issue_cmd(make_cmd(brcag_pkg::KIND_NONE, -1, -1, -1, -1, 8191, 8191));
   endtask

   // largest buffers, clamped sizes and offsets that wrap
   task automatic test_max_sizes();
      load_config(make_cfg(4096, 4096, 8191, brcag_pkg::FMT_BGR32,
                           8191, 8191, 8191, brcag_pkg::FMT_BGR32));
      issue_cmd(make_cmd(brcag_pkg::KIND_COPY_ALL, 0, 0, 0, 0, 0, 0));
      issue_cmd(make_cmd(brcag_pkg::KIND_COPY_AREA, 4095, 4095, -8192, -8192, 8191, 8191));
      issue_cmd(make_cmd(brcag_pkg::KIND_MOVE, 0, 4095, 0, 0, 8191, 8191));
   endtask

   task automatic test_random_traffic();
      int count;
      for (int phase = 0; phase < 12; phase++) begin
         load_config(random_cfg(phase % 4));
         // one long burst with start held high every cycle
         idle_enable = (phase != 5);
         count = (phase == 5) ? 300 : 145;
         repeat (count) issue_cmd(random_cmd(fb_cfg));
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      reset      <= 1'b1;
      start      <= 1'b0;
      req_kind   <= brcag_pkg::KIND_COPY_ALL;
      req_pos_x  <= '0;
      req_pos_y  <= '0;
      req_rect_x <= '0;
      req_rect_y <= '0;
      req_rect_w <= '0;
      req_rect_h <= '0;
      csr_we     <= 1'b0;
      csr_index  <= brcag_pkg::CSR_DST_WIDTH;
      csr_wdata  <= '0;
      fb_cfg = '0;
      mismatch_count = 0;
      idle_enable = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_copy_whole();
      test_copy_area();
      test_move();
      test_format_checks();
      test_unknown_kind();
      test_max_sizes();
      test_random_traffic();
      settle();

      if (mismatch_count == 0)
         $display("blit_rect_clip_address_gen_unit regression: pass");
      else
         $display("blit_rect_clip_address_gen_unit regression: fail");
      $finish;
   end

endmodule
